FILE: hw/rtl/css_pkg.sv
package css_pkg;

	// Store geometry
	localparam int CAPACITY = 64;
	localparam int SLOT_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int WORD_W   = 32;

	// Field widths of the stream items
	localparam int KIND_W   = 3;
	localparam int STAT_W   = 3;
	localparam int IDX_W    = 7;

	// Command kinds
	localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
	localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_INSERT     = 3'd4;
	localparam logic [KIND_W-1:0] KIND_SEARCH     = 3'd5;

	// Result status codes
	localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd1;
	localparam logic [STAT_W-1:0] STAT_BADPOS   = 3'd2;
	localparam logic [STAT_W-1:0] STAT_FULL     = 3'd3;
	localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd4;

	// Index reported when nothing was found
	localparam logic [IDX_W-1:0] IDX_NONE = '1;

	// One access to the entry memory
	typedef struct packed {
		logic              we;
		logic [SLOT_W-1:0] waddr;
		logic [WORD_W-1:0] wdata;
		logic [SLOT_W-1:0] raddr;
	} mem_req_t;

	// One finished result
	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [IDX_W-1:0]  found_index;
		logic [IDX_W-1:0]  count;
	} result_t;

	// Physical slot of logical element idx, idx from 0 up to CAPACITY
	function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W-1:0] front,
	                                              input logic [CNT_W-1:0]  idx);
		logic [CNT_W:0] s;
		s = (CNT_W+1)'(front) + (CNT_W+1)'(idx);
		if (s >= (CNT_W+1)'(CAPACITY)) begin
			s = s - (CNT_W+1)'(CAPACITY);
		end
		return s[SLOT_W-1:0];
	endfunction

endpackage

FILE: hw/rtl/circular_sequence_store_unit.sv
// Channel  Dir  tdata                               tuser
// s_       in   [31:0] value, [38:32] position      [2:0] kind
// m_       out  [6:0] found_index, [13:7] count     [2:0] status
//
// Push, pop and rejected commands pass through the DONE state into the output register.
// Insert at position p moves the stored words from p onwards back one place, last
// first, then writes the new word at p: one memory port moves one word a cycle towards the back.
// Search stops at the first match or after the last entry: one entry is read and compared a cycle.
// A finished result waits in the output register; s_tready is high while
// no command is in progress. Reset clears the count and front pointer.
module circular_sequence_store_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // value, position, zero pad
	input  logic [2:0]  s_tuser,   // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // found_index, count, zero pad
	output logic [2:0]  m_tuser    // status
);
	import css_pkg::*;

	mem_req_t          mem_req;
	logic [WORD_W-1:0] rd_data;
	logic              out_free;
	logic              res_load;
	result_t           res;
	result_t           res_q;
	logic              m_tvalid_q;

	assign out_free = !m_tvalid_q || m_tready;

	css_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.kind     (s_tuser),
		.value    (s_tdata[31:0]),
		.position (s_tdata[38:32]),
		.mem_req  (mem_req),
		.rd_data  (rd_data),
		.out_free (out_free),
		.res_load (res_load),
		.res      (res)
	);

	css_mem u_mem (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			res_q      <= '0;
		end else begin
			if (res_load) begin
				m_tvalid_q <= 1'b1;
				res_q      <= res;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, res_q.count, res_q.found_index};
	assign m_tuser  = res_q.status;

endmodule

FILE: hw/rtl/css_mem.sv
module css_mem (
	input  logic                clk,
	input  css_pkg::mem_req_t   req,
	output logic [31:0]         rd_data
);
	import css_pkg::*;

	logic [WORD_W-1:0] mem [CAPACITY];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rd_data <= mem[req.raddr];
	end

endmodule

FILE: hw/rtl/css_ctrl.sv
module css_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [2:0]          kind,
	input  logic [31:0]         value,
	input  logic [6:0]          position,
	output css_pkg::mem_req_t   mem_req,
	input  logic [31:0]         rd_data,
	input  logic                out_free,
	output logic                res_load,
	output css_pkg::result_t    res
);
	import css_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SHIFT = 2'd1;
	localparam logic [1:0] S_SCAN  = 2'd2;
	localparam logic [1:0] S_DONE  = 2'd3;

	logic [1:0]        state_q;
	logic [SLOT_W-1:0] front_q;
	logic [CNT_W-1:0]  count_q;
	logic [WORD_W-1:0] val_q;
	logic [CNT_W-1:0]  pos_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  scan_idx_q;
	logic [STAT_W-1:0] stat_q;
	logic [IDX_W-1:0]  found_q;
	logic              pend_s1;
	logic [CNT_W-1:0]  wr_idx_s1;
	logic              chk_vld_s1;
	logic [CNT_W-1:0]  chk_idx_s1;

	logic              full;
	logic              empty;
	logic [SLOT_W-1:0] front_dec;
	logic              hit;

	assign full      = (count_q == CNT_W'(CAPACITY));
	assign empty     = (count_q == '0);
	assign front_dec = (front_q == '0) ? SLOT_W'(CAPACITY - 1) : front_q - 1'b1;
	assign hit       = chk_vld_s1 && (rd_data == val_q);

	assign in_ready = (state_q == S_IDLE);
	assign res_load = (state_q == S_DONE) && out_free;
	assign res      = '{status: stat_q, found_index: found_q, count: IDX_W'(count_q)};

	// Memory port: pushes write at acceptance, shifts move one word a cycle
	always_comb begin
		mem_req = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && !full) begin
					if (kind == KIND_PUSH_FRONT) begin
						mem_req.we    = 1'b1;
						mem_req.waddr = front_dec;
						mem_req.wdata = value;
					end else if (kind == KIND_PUSH_BACK) begin
						mem_req.we    = 1'b1;
						mem_req.waddr = slot_of(front_q, count_q);
						mem_req.wdata = value;
					end
				end
			end
			S_SHIFT: begin
				mem_req.raddr = slot_of(front_q, CNT_W'(pos_q + rem_q - 1'b1));
				if (pend_s1) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = slot_of(front_q, wr_idx_s1);
					mem_req.wdata = rd_data;
				end else if (rem_q == '0) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = slot_of(front_q, pos_q);
					mem_req.wdata = val_q;
				end
			end
			S_SCAN: begin
				mem_req.raddr = slot_of(front_q, scan_idx_q);
			end
			S_DONE: begin
				mem_req = '0;
			end
			default: begin
				mem_req = '0;
			end
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			front_q    <= '0;
			count_q    <= '0;
			val_q      <= '0;
			pos_q      <= '0;
			rem_q      <= '0;
			scan_idx_q <= '0;
			stat_q     <= STAT_OK;
			found_q    <= IDX_NONE;
			pend_s1    <= 1'b0;
			wr_idx_s1  <= '0;
			chk_vld_s1 <= 1'b0;
			chk_idx_s1 <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						val_q   <= value;
						pos_q   <= position;
						found_q <= IDX_NONE;
						stat_q  <= STAT_OK;
						state_q <= S_DONE;
						unique case (kind)
							KIND_PUSH_FRONT: begin
								if (full) begin
									stat_q <= STAT_FULL;
								end else begin
									front_q <= front_dec;
									count_q <= count_q + 1'b1;
								end
							end
							KIND_PUSH_BACK: begin
								if (full) begin
									stat_q <= STAT_FULL;
								end else begin
									count_q <= count_q + 1'b1;
								end
							end
							KIND_POP_FRONT: begin
								if (empty) begin
									stat_q <= STAT_EMPTY;
								end else begin
									front_q <= slot_of(front_q, CNT_W'(1));
									count_q <= count_q - 1'b1;
								end
							end
							KIND_POP_BACK: begin
								if (empty) begin
									stat_q <= STAT_EMPTY;
								end else begin
									count_q <= count_q - 1'b1;
								end
							end
							KIND_INSERT: begin
								if (position > count_q) begin
									stat_q <= STAT_BADPOS;
								end else if (full) begin
									stat_q <= STAT_FULL;
								end else begin
									rem_q   <= count_q - position;
									pend_s1 <= 1'b0;
									state_q <= S_SHIFT;
								end
							end
							KIND_SEARCH: begin
								scan_idx_q <= '0;
								chk_vld_s1 <= 1'b0;
								state_q    <= S_SCAN;
							end
							default: begin
								stat_q <= STAT_BADPOS;
							end
						endcase
					end
				end
				// Move the tail back one place, last element first
				S_SHIFT: begin
					pend_s1 <= (rem_q != '0);
					if (rem_q != '0) begin
						wr_idx_s1 <= CNT_W'(pos_q + rem_q);
						rem_q     <= rem_q - 1'b1;
					end else if (!pend_s1) begin
						count_q <= count_q + 1'b1;
						state_q <= S_DONE;
					end
				end
				// Read one entry a cycle, compare it the cycle after
				S_SCAN: begin
					if (hit) begin
						found_q <= IDX_W'(chk_idx_s1);
						stat_q  <= STAT_OK;
						state_q <= S_DONE;
					end else if (scan_idx_q == count_q) begin
						stat_q  <= STAT_NOTFOUND;
						state_q <= S_DONE;
					end else begin
						chk_vld_s1 <= 1'b1;
						chk_idx_s1 <= scan_idx_q;
						scan_idx_q <= scan_idx_q + 1'b1;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_scan_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> !mem_req.we)
		else $error("memory written during search");

	a_done_holds_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) |=> $stable(count_q) && $stable(front_q))
		else $error("store changed while result pending");

	a_found_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_load && (res.found_index != IDX_NONE) |-> (res.status == STAT_OK))
		else $error("index reported with failing status");
`endif

endmodule

FILE: verif/circular_sequence_store_unit_tb.sv
module circular_sequence_store_unit_tb;
	import css_pkg::*;

	// Kinds outside the defined set: the block must reject them
	localparam logic [KIND_W-1:0] KIND_RESERVED_LO = 3'd6;
	localparam logic [KIND_W-1:0] KIND_RESERVED_HI = 3'd7;

	// Random command mixes
	localparam int REGIME_FILL  = 0;
	localparam int REGIME_DRAIN = 1;
	localparam int REGIME_MIXED = 2;

	localparam int RANDOM_PER_PHASE = 445;
	localparam int HOLD_CYCLES      = 400;
	localparam int STALL_LIMIT      = 4000;
	localparam int DRAIN_CYCLES     = CAPACITY + 8;
	localparam int N_DIRECTED       = 20;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata  = '0;   // value, position, zero pad
	logic [2:0]  s_tuser  = '0;   // kind
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;         // found_index, count, zero pad
	logic [2:0]  m_tuser;         // status

	circular_sequence_store_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Words held, front first, and results still owed by the block
	logic [WORD_W-1:0] held_words[$];
	result_t           outcomes_due[$];

	int source_idle_pct = 0;
	int sink_idle_pct   = 0;
	int holds_asked     = 0;
	int holds_served    = 0;
	int hold_left       = 0;
	int err_count       = 0;
	int commands_sent   = 0;
	int results_seen    = 0;
	int stalled_cycles  = 0;
	int peak_held       = 0;
	int status_tally[8];

	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [WORD_W-1:0] word;
		logic [IDX_W-1:0]  pos;
		bit                typed;
		result_t           want;
	} directed_row_t;

	// Directed commands; typed results where they are obvious
	directed_row_t directed_rows [N_DIRECTED] = '{
		'{KIND_POP_FRONT,   32'h0000_0000, 7'd0,   1'b1, '{STAT_EMPTY,    IDX_NONE, 7'd0}},
		'{KIND_POP_BACK,    32'hFFFF_FFFF, 7'd0,   1'b1, '{STAT_EMPTY,    IDX_NONE, 7'd0}},
		'{KIND_SEARCH,      32'h0000_0000, 7'd0,   1'b1, '{STAT_NOTFOUND, IDX_NONE, 7'd0}},
		'{KIND_INSERT,      32'h0000_0001, 7'd1,   1'b1, '{STAT_BADPOS,   IDX_NONE, 7'd0}},
		'{KIND_INSERT,      32'h5A5A_A5A5, 7'd127, 1'b1, '{STAT_BADPOS,   IDX_NONE, 7'd0}},
		'{KIND_RESERVED_LO, 32'h1234_5678, 7'd0,   1'b1, '{STAT_BADPOS,   IDX_NONE, 7'd0}},
		'{KIND_RESERVED_HI, 32'hFFFF_FFFF, 7'd127, 1'b1, '{STAT_BADPOS,   IDX_NONE, 7'd0}},
		'{KIND_INSERT,      32'h8000_0000, 7'd0,   1'b1, '{STAT_OK,       IDX_NONE, 7'd1}},
		'{KIND_PUSH_BACK,   32'h7FFF_FFFF, 7'd64,  1'b1, '{STAT_OK,       IDX_NONE, 7'd2}},
		'{KIND_PUSH_FRONT,  32'h0000_0000, 7'd0,   1'b1, '{STAT_OK,       IDX_NONE, 7'd3}},
		'{KIND_PUSH_BACK,   32'hFFFF_FFFF, 7'd0,   1'b1, '{STAT_OK,       IDX_NONE, 7'd4}},
		'{KIND_SEARCH,      32'h8000_0000, 7'd0,   1'b1, '{STAT_OK,       7'd1,     7'd4}},
		'{KIND_INSERT,      32'h7FFF_FFFF, 7'd4,   1'b0, '{STAT_OK,       IDX_NONE, 7'd0}},
		'{KIND_INSERT,      32'h7FFF_FFFF, 7'd2,   1'b0, '{STAT_OK,       IDX_NONE, 7'd0}},
		'{KIND_SEARCH,      32'h7FFF_FFFF, 7'd0,   1'b0, '{STAT_OK,       IDX_NONE, 7'd0}},
		'{KIND_SEARCH,      32'h1234_5678, 7'd0,   1'b0, '{STAT_OK,       IDX_NONE, 7'd0}},
		'{KIND_INSERT,      32'h0000_0007, 7'd7,   1'b0, '{STAT_OK,       IDX_NONE, 7'd0}},
		'{KIND_POP_FRONT,   32'h0000_0000, 7'd0,   1'b0, '{STAT_OK,       IDX_NONE, 7'd0}},
		'{KIND_POP_BACK,    32'h0000_0000, 7'd0,   1'b0, '{STAT_OK,       IDX_NONE, 7'd0}},
		'{KIND_SEARCH,      32'h7FFF_FFFF, 7'd0,   1'b0, '{STAT_OK,       IDX_NONE, 7'd0}}
	};

	// Apply one command to the held words and return the result it gives
	function automatic result_t store_outcome(input logic [KIND_W-1:0] kind,
	                                          input logic [WORD_W-1:0] word,
	                                          input logic [IDX_W-1:0]  pos);
		result_t r;
		r.status      = STAT_OK;
		r.found_index = IDX_NONE;
		case (kind)
			KIND_PUSH_FRONT: begin
				if (held_words.size() >= CAPACITY) r.status = STAT_FULL;
				else held_words.insert(0, word);
			end
			KIND_PUSH_BACK: begin
				if (held_words.size() >= CAPACITY) r.status = STAT_FULL;
				else held_words.insert(held_words.size(), word);
			end
			KIND_POP_FRONT: begin
				if (held_words.size() == 0) r.status = STAT_EMPTY;
				else held_words.delete(0);
			end
			KIND_POP_BACK: begin
				if (held_words.size() == 0) r.status = STAT_EMPTY;
				else held_words.delete(held_words.size() - 1);
			end
			KIND_INSERT: begin
				// position check wins over the full check
				if (int'(pos) > held_words.size()) r.status = STAT_BADPOS;
				else if (held_words.size() >= CAPACITY) r.status = STAT_FULL;
				else held_words.insert(int'(pos), word);
			end
			KIND_SEARCH: begin
				r.status = STAT_NOTFOUND;
				for (int i = 0; i < held_words.size(); i++) begin
					if (held_words[i] == word) begin
						r.status      = STAT_OK;
						r.found_index = IDX_W'(i);
						break;
					end
				end
			end
			default: r.status = STAT_BADPOS;
		endcase
		r.count = IDX_W'(held_words.size());
		status_tally[r.status]++;
		if (held_words.size() > peak_held) peak_held = held_words.size();
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		err_count++;
	endtask

	// Offer one command and wait for its transfer; idle cycles carry noise
	task automatic send_command(input logic [KIND_W-1:0] kind, input logic [WORD_W-1:0] word,
	                            input logic [IDX_W-1:0] pos, input bit typed,
	                            input result_t want);
		result_t r;
		while ($urandom_range(99) < source_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata  <= {1'b0, 7'($urandom), 32'($urandom)};
			s_tuser  <= 3'($urandom);
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, pos, word};
		s_tuser  <= kind;
		do @(negedge clk); while (s_tready !== 1'b1);
		@(posedge clk);
		r = store_outcome(kind, word, pos);
		outcomes_due.insert(outcomes_due.size(), typed ? want : r);
		commands_sent++;
	endtask

	// Receiver: random back-pressure, or a long hold-off when asked
	always @(posedge clk) begin
		if (holds_served != holds_asked) begin
			holds_served++;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	// Result check, sampled mid-cycle so values are settled
	always @(negedge clk) begin
		result_t want;
		if (arst_n && m_tvalid === 1'b1 && m_tready === 1'b1) begin
			results_seen++;
			if (outcomes_due.size() == 0) begin
				report_mismatch("result with no command outstanding (status)",
				                int'(m_tuser), -1);
			end else begin
				want = outcomes_due[0];
				outcomes_due.delete(0);
				if (m_tuser !== want.status)
					report_mismatch("status", int'(m_tuser), int'(want.status));
				if (m_tdata[6:0] !== want.found_index)
					report_mismatch("found_index", int'($signed(m_tdata[6:0])),
					                int'($signed(want.found_index)));
				if (m_tdata[13:7] !== want.count)
					report_mismatch("count", int'(m_tdata[13:7]), int'(want.count));
			end
		end
	end

	// Watchdog on cycles with no transfer on either side
	always @(negedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stalled_cycles = 0;
		else stalled_cycles++;
		if (stalled_cycles >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles, %0d results outstanding",
			         $time, stalled_cycles, outcomes_due.size());
			$display("circular_sequence_store_unit_tb: errors");
			$finish;
		end
	end

	initial begin
		logic [KIND_W-1:0] k;
		logic [WORD_W-1:0] w;
		logic [IDX_W-1:0]  p;
		int roll;
		int regime;
		int regime_left;

		regime      = REGIME_FILL;
		regime_left = 0;
		source_idle_pct = 18;
		sink_idle_pct   = 64;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < N_DIRECTED; r++)
			send_command(directed_rows[r].kind, directed_rows[r].word, directed_rows[r].pos,
			             directed_rows[r].typed, directed_rows[r].want);

		// Three idling phases; the last one opens with a long output hold-off
		for (int ph = 0; ph < 3; ph++) begin
			source_idle_pct = (ph == 0) ? 18 : (ph == 1) ? 64 : 0;
			sink_idle_pct   = (ph == 0) ? 64 : (ph == 1) ? 18 : 0;
			if (ph == 2) holds_asked++;
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				if (regime_left == 0) begin
					regime      = $urandom_range(2);
					regime_left = (regime == REGIME_FILL) ? $urandom_range(100, 160)
					                                      : $urandom_range(20, 100);
				end
				regime_left--;

				// kind, weighted by the current mix
				roll = $urandom_range(99);
				case (regime)
					REGIME_FILL:
						k = (roll < 30) ? KIND_PUSH_FRONT : (roll < 60) ? KIND_PUSH_BACK :
						    (roll < 80) ? KIND_INSERT     : (roll < 90) ? KIND_SEARCH :
						    (roll < 94) ? KIND_POP_FRONT  : (roll < 98) ? KIND_POP_BACK :
						    KIND_RESERVED_LO;
					REGIME_DRAIN:
						k = (roll < 35) ? KIND_POP_FRONT  : (roll < 70) ? KIND_POP_BACK :
						    (roll < 85) ? KIND_SEARCH     : (roll < 90) ? KIND_PUSH_FRONT :
						    (roll < 95) ? KIND_PUSH_BACK  : (roll < 98) ? KIND_INSERT :
						    KIND_RESERVED_HI;
					default:
						k = (roll < 96) ? KIND_W'(roll % 6) :
						    (roll[0] ? KIND_RESERVED_HI : KIND_RESERVED_LO);
				endcase

				// word: wide random, a narrow set for duplicates, or the extremes
				roll = $urandom_range(99);
				if (roll < 50) w = $urandom;
				else if (roll < 80) w = $urandom_range(8) - 4;
				else if (roll < 90) w = roll[0] ? 32'h8000_0000 : 32'h7FFF_FFFF;
				else w = roll[0] ? 32'hFFFF_FFFF : 32'h0000_0000;
				if (k == KIND_SEARCH && held_words.size() > 0 && $urandom_range(99) < 70)
					w = held_words[$urandom_range(held_words.size() - 1)];

				// position: mostly legal for inserts, anything otherwise
				if (k == KIND_INSERT && $urandom_range(99) < 85)
					p = IDX_W'($urandom_range(held_words.size()));
				else
					p = IDX_W'($urandom_range(127));

				send_command(k, w, p, 1'b0, '0);
			end
		end

		s_tvalid <= 1'b0;
		while (outcomes_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d commands, %0d results: %0d ok, %0d empty pops, %0d rejected",
		         commands_sent, results_seen, status_tally[STAT_OK], status_tally[STAT_EMPTY],
		         status_tally[STAT_BADPOS]);
		$display("  %0d refused as full, %0d missed searches, peak fill %0d of %0d, %0d-cycle hold-off",
		         status_tally[STAT_FULL], status_tally[STAT_NOTFOUND], peak_held, CAPACITY,
		         HOLD_CYCLES);
		if (err_count == 0) begin
			$display("circular_sequence_store_unit_tb: clean");
		end else begin
			$display("circular_sequence_store_unit_tb: errors");
		end
		$finish;
	end

endmodule
